// ===== sv/pidc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants and types for the PID controller with integral clamp.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int OPND_W = 32;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 5;
   localparam int REG_W  = 31;

   localparam logic [2:0] REG_GAIN_P       = 3'd0;
   localparam logic [2:0] REG_GAIN_I       = 3'd1;
   localparam logic [2:0] REG_GAIN_D       = 3'd2;
   localparam logic [2:0] REG_SETPOINT     = 3'd3;
   localparam logic [2:0] REG_INT_LIMIT    = 3'd4;
   localparam logic [2:0] REG_INT_RANGE    = 3'd5;
   localparam logic [2:0] REG_ARRIVE_TOL   = 3'd6;

   localparam int LIMIT_RESET_INT = 20;
   localparam int RANGE_RESET_INT = 50;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_ERR   = 10'b00_0000_0010,
      ST_MULP  = 10'b00_0000_0100,
      ST_MULD  = 10'b00_0000_1000,
      ST_SUM   = 10'b00_0001_0000,
      ST_CLAMP = 10'b00_0010_0000,
      ST_MULI0 = 10'b00_0100_0000,
      ST_MULI1 = 10'b00_1000_0000,
      ST_MULI2 = 10'b01_0000_0000,
      ST_OUT   = 10'b10_0000_0000
   } state_type;

endpackage
`default_nettype wire

// ===== sv/pidc_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_mul
// Shared unsigned operand multiplier with a registered product.
// ----------------------------------------------------------------------------
module pidc_mul (
   input  wire logic                          clock,
   input  wire logic [pidc_pkg::OPND_W-1:0]   mul_a,
   input  wire logic [pidc_pkg::OPND_W-1:0]   mul_b,
   output logic      [2*pidc_pkg::OPND_W-1:0] prod_ff
);
   import pidc_pkg::*;

   logic [2*OPND_W-1:0] prod_in;

   assign prod_in = (2*OPND_W)'(mul_a) * (2*OPND_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

// ===== sv/pidc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pidc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div #(
   parameter int DVD_W = 47
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DVD_W-1:0]            dividend,
   input  wire logic [pidc_pkg::OPND_W-1:0] divisor,
   output logic                             done,
   output logic [DVD_W-1:0]                 quotient
);
   import pidc_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [OPND_W-1:0] rem_ff, rem_in;
   logic [OPND_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [OPND_W+1:0] trial;

   assign trial = {1'b0, rem_ff, quot_ff[DVD_W-1]} - (OPND_W+2)'(dvs_ff);

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         quot_in = dividend;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!trial[OPND_W+1]) begin
            rem_in  = trial[OPND_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[OPND_W-2:0], quot_ff[DVD_W-1]};
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ===== sv/pid_controller_windup_clamp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_windup_clamp_core
// PID controller in signed fixed point with an integral windup clamp.
// ----------------------------------------------------------------------------
// A request's length is set by the restoring divider that forms the clamp
// bound (integral_limit << FRAC_BITS) / gain_i one quotient bit per cycle, and
// the next request can be taken at the earliest in the same cycle that the
// result appears. The P and D products go through one shared 32x32
// multiplier while the divider runs, and the I product takes two passes
// through it after the clamp. req_stall is high from acceptance until the
// sequencer returns to idle; a finished result waits in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module pid_controller_windup_clamp_core #(
   parameter int FRAC_BITS = 16,
   parameter int SUM_WIDTH = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_measurement,
   input  wire logic                          req_restart,
   input  wire logic                          req_clear_arrived,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [31:0]                 rsp_drive,
   output logic                               rsp_arrived,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pidc_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [pidc_pkg::DATA_W-1:0]   pwdata,
   output logic      [pidc_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import pidc_pkg::*;

   localparam int QUOT_W = REG_W + FRAC_BITS;
   localparam int CMP_W  = (QUOT_W > SUM_WIDTH) ? QUOT_W : SUM_WIDTH;
   localparam int TERM_W = 2*OPND_W + 1;
   localparam int IPRD_W = 3*OPND_W;
   localparam int TOT_W  = TERM_W + 2;
   localparam logic [REG_W-1:0] LIMIT_RST = REG_W'(LIMIT_RESET_INT * (2**FRAC_BITS));
   localparam logic [REG_W-1:0] RANGE_RST = REG_W'(RANGE_RESET_INT * (2**FRAC_BITS));
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH:0]   SUM_HI  = (SUM_WIDTH+1)'(SUM_MAX);
   localparam logic signed [SUM_WIDTH:0]   SUM_LO  = -SUM_HI;
   localparam logic signed [TOT_W-1:0]     DRV_MAX = TOT_W'(32'h7fff_ffff);
   localparam logic signed [TOT_W-1:0]     DRV_MIN = -DRV_MAX - TOT_W'(1);

   // configuration registers
   logic [31:0]       gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [31:0] setpoint_ff;
   logic [REG_W-1:0]  limit_ff, range_ff, tol_ff;
   logic              csr_wr;
   logic [2:0]        csr_idx;

   // sequencer and datapath state
   state_type                    state_ff, state_in;
   logic signed [31:0]           meas_ff, meas_in;
   logic                         restart_ff, restart_in;
   logic                         clear_ff, clear_in;
   logic                         first_ff, first_in;
   logic signed [31:0]           err_ff, err_in;
   logic signed [31:0]           prev_ff, prev_in;
   logic signed [32:0]           diff_ff, diff_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;
   logic                         arrived_ff, arrived_in;
   logic                         zero_ff, zero_in;
   logic signed [TERM_W-1:0]     p_ff, p_in;
   logic signed [TERM_W-1:0]     d_ff, d_in;
   logic signed [TERM_W-1:0]     i_ff, i_in;
   logic [2*OPND_W-1:0]          ilo_ff, ilo_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]           rsp_drive_ff, rsp_drive_in;
   logic                         rsp_arrived_ff, rsp_arrived_in;

   // combinational datapath
   logic signed [32:0]           err_raw;
   logic signed [31:0]           err_sat;
   logic [31:0]                  err_sat_mag;
   logic [31:0]                  err_mag;
   logic [32:0]                  diff_mag;
   logic [SUM_WIDTH-1:0]         sum_mag;
   logic [2*OPND_W-1:0]          sum_mag64;
   logic signed [SUM_WIDTH:0]    sum_add;
   logic [TERM_W-1:0]            p_mag;
   logic                         term_neg;
   logic signed [TERM_W-1:0]     prod_x;
   logic signed [TERM_W-1:0]     term_pd;
   logic [IPRD_W-1:0]            i_full;
   logic signed [IPRD_W:0]       i_x;
   logic signed [IPRD_W:0]       i_term;
   logic signed [TOT_W-1:0]      total;
   logic signed [31:0]           total_sat;
   logic [SUM_WIDTH-1:0]         quot_s;
   logic [OPND_W-1:0]            mul_a, mul_b;
   logic [2*OPND_W-1:0]          mul_prod;
   logic                         div_start;
   logic                         div_done;
   logic [QUOT_W-1:0]            div_quot;
   logic [QUOT_W-1:0]            div_dividend;

   pidc_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   pidc_div #(
      .DVD_W (QUOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gain_i_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign div_dividend = QUOT_W'(limit_ff) << FRAC_BITS;
   assign div_start    = (state_ff == ST_ERR);

   // configuration port
   assign pready  = 1'b1;
   assign csr_idx = paddr[4:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         setpoint_ff <= '0;
         limit_ff    <= LIMIT_RST;
         range_ff    <= RANGE_RST;
         tol_ff      <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_GAIN_P:     gain_p_ff   <= pwdata;
            REG_GAIN_I:     gain_i_ff   <= pwdata;
            REG_GAIN_D:     gain_d_ff   <= pwdata;
            REG_SETPOINT:   setpoint_ff <= pwdata;
            REG_INT_LIMIT:  limit_ff    <= pwdata[REG_W-1:0];
            REG_INT_RANGE:  range_ff    <= pwdata[REG_W-1:0];
            REG_ARRIVE_TOL: tol_ff      <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_GAIN_P:     prdata = gain_p_ff;
         REG_GAIN_I:     prdata = gain_i_ff;
         REG_GAIN_D:     prdata = gain_d_ff;
         REG_SETPOINT:   prdata = setpoint_ff;
         REG_INT_LIMIT:  prdata = DATA_W'(limit_ff);
         REG_INT_RANGE:  prdata = DATA_W'(range_ff);
         REG_ARRIVE_TOL: prdata = DATA_W'(tol_ff);
         default:        prdata = '0;
      endcase
   end

   // error and magnitudes
   assign err_raw     = {setpoint_ff[31], setpoint_ff} - {meas_ff[31], meas_ff};
   assign err_sat     = (err_raw[32] != err_raw[31]) ?
                        (err_raw[32] ? 32'h8000_0000 : 32'h7fff_ffff) : err_raw[31:0];
   assign err_sat_mag = err_sat[31] ? -err_sat : err_sat;
   assign err_mag     = err_ff[31] ? -err_ff : err_ff;
   assign diff_mag    = diff_ff[32] ? -diff_ff : diff_ff;
   assign sum_mag     = sum_ff[SUM_WIDTH-1] ? -sum_ff : sum_ff;
   assign sum_mag64   = (2*OPND_W)'(sum_mag);
   assign sum_add     = {sum_ff[SUM_WIDTH-1], sum_ff} + (SUM_WIDTH+1)'(err_ff);
   assign p_mag       = p_ff[TERM_W-1] ? -p_ff : p_ff;
   assign quot_s      = SUM_WIDTH'(div_quot);

   // product to term, floor shift
   assign term_neg = (state_ff == ST_MULD) ? err_ff[31] : diff_ff[32];
   assign prod_x   = {1'b0, mul_prod};
   assign term_pd  = (term_neg ? -prod_x : prod_x) >>> FRAC_BITS;
   assign i_full   = {mul_prod, {OPND_W{1'b0}}} + IPRD_W'(ilo_ff);
   assign i_x      = {1'b0, i_full};
   assign i_term   = (sum_ff[SUM_WIDTH-1] ? -i_x : i_x) >>> FRAC_BITS;

   assign total     = TOT_W'(p_ff) + TOT_W'(i_ff) + TOT_W'(d_ff);
   assign total_sat = (total > DRV_MAX) ? 32'h7fff_ffff :
                      (total < DRV_MIN) ? 32'h8000_0000 : total[31:0];

   // multiplier operands
   always_comb begin
      case (state_ff)
         ST_MULP:  mul_a = gain_p_ff;
         ST_MULD:  mul_a = gain_d_ff;
         default:  mul_a = gain_i_ff;
      endcase
      case (state_ff)
         ST_MULP:  mul_b = err_mag;
         ST_MULD:  mul_b = diff_mag[OPND_W-1:0];
         ST_MULI0: mul_b = sum_mag64[OPND_W-1:0];
         ST_MULI1: mul_b = sum_mag64[2*OPND_W-1:OPND_W];
         default:  mul_b = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      meas_in        = meas_ff;
      restart_in     = restart_ff;
      clear_in       = clear_ff;
      first_in       = first_ff;
      err_in         = err_ff;
      prev_in        = prev_ff;
      diff_in        = diff_ff;
      sum_in         = sum_ff;
      arrived_in     = arrived_ff;
      zero_in        = zero_ff;
      p_in           = p_ff;
      d_in           = d_ff;
      i_in           = i_ff;
      ilo_in         = ilo_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_arrived_in = rsp_arrived_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in    = req_measurement;
               restart_in = req_restart;
               clear_in   = req_clear_arrived;
               state_in   = ST_ERR;
            end
         end
         ST_ERR: begin
            err_in = err_sat;
            if (first_ff || restart_ff) begin
               first_in = 1'b0;
               prev_in  = err_sat;
               sum_in   = '0;
            end
            arrived_in = (arrived_ff && !clear_ff) || (err_sat_mag <= 32'(tol_ff));
            state_in   = ST_MULP;
         end
         ST_MULP: begin
            diff_in  = {err_ff[31], err_ff} - {prev_ff[31], prev_ff};
            prev_in  = err_ff;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            p_in     = term_pd;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            d_in = term_pd;
            if (p_mag >= TERM_W'(range_ff)) begin
               zero_in = 1'b1;
               sum_in  = '0;
            end else begin
               zero_in = 1'b0;
               if (sum_add > SUM_HI) begin
                  sum_in = SUM_MAX;
               end else if (sum_add < SUM_LO) begin
                  sum_in = -SUM_MAX;
               end else begin
                  sum_in = sum_add[SUM_WIDTH-1:0];
               end
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (div_done) begin
               if (!zero_ff && (gain_i_ff != '0) && (CMP_W'(sum_mag) > CMP_W'(div_quot))) begin
                  sum_in = sum_ff[SUM_WIDTH-1] ? -quot_s : quot_s;
               end
               state_in = ST_MULI0;
            end
         end
         ST_MULI0: begin
            state_in = ST_MULI1;
         end
         ST_MULI1: begin
            ilo_in   = mul_prod;
            state_in = ST_MULI2;
         end
         ST_MULI2: begin
            i_in     = i_term[TERM_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_drive_in   = total_sat;
               rsp_arrived_in = arrived_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= 1'b1;
         prev_ff      <= '0;
         sum_ff       <= '0;
         arrived_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         arrived_ff   <= arrived_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      meas_ff        <= meas_in;
      restart_ff     <= restart_in;
      clear_ff       <= clear_in;
      err_ff         <= err_in;
      diff_ff        <= diff_in;
      zero_ff        <= zero_in;
      p_ff           <= p_in;
      d_ff           <= d_in;
      i_ff           <= i_in;
      ilo_ff         <= ilo_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_arrived_ff <= rsp_arrived_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_arrived = rsp_arrived_ff;

endmodule
`default_nettype wire

// ===== tb/pid_drive_checker.sv =====
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the register port and both channels of the PID core, keeps its own
// copy of the controller state and settings, forecasts drive and arrived for
// every accepted request and compares each accepted response in order.
// ----------------------------------------------------------------------------
module pid_drive_checker #(
   parameter int FRAC_BITS = 16,
   parameter int SUM_WIDTH = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic signed [31:0]            req_measurement,
   input  wire logic                          req_restart,
   input  wire logic                          req_clear_arrived,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic signed [31:0]            rsp_drive,
   input  wire logic                          rsp_arrived,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [pidc_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [pidc_pkg::DATA_W-1:0]   pwdata,
   input  wire logic                          pready,
   output int                                 mismatches,
   output int                                 awaiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import pidc_pkg::*;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               arrived;
   } pid_result_type;

   pid_result_type drive_forecast[$];

   bit [31:0] kp, ki, kd;
   longint    target;
   bit [63:0] i_limit, i_range, tol;

   bit        first_pending;
   longint    last_err;
   longint    err_acc;
   bit        arrived_q;

   function automatic bit [63:0] magnitude(input longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint sat_word(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // floor(gain * x / 2^FRAC_BITS)
   function automatic longint scale_gain(input bit [31:0] gain, input longint x);
      bit [63:0] m;
      m = {32'h0, gain} * magnitude(x);
      if (x >= 0) return longint'(m >> FRAC_BITS);
      m = (m + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS;
      return -longint'(m);
   endfunction

   function automatic void write_register(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_GAIN_P:     kp = value;
         REG_GAIN_I:     ki = value;
         REG_GAIN_D:     kd = value;
         REG_SETPOINT:   target = longint'(signed'(value));
         REG_INT_LIMIT:  i_limit = {33'h0, value[30:0]};
         REG_INT_RANGE:  i_range = {33'h0, value[30:0]};
         REG_ARRIVE_TOL: tol = {33'h0, value[30:0]};
         default: ;
      endcase
   endfunction

   function automatic pid_result_type pid_step(input logic signed [31:0] meas,
                                               input logic restart, input logic clr);
      longint         err, p, i, d, sum_max;
      bit [63:0]      bound;
      pid_result_type r;
      sum_max = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
      if (clr) arrived_q = 1'b0;
      err = sat_word(target - longint'(meas));
      if (first_pending || restart) begin
         first_pending = 1'b0;
         last_err = err;
         err_acc = 0;
      end
      p = scale_gain(kp, err);
      if (magnitude(p) >= i_range) begin
         err_acc = 0;
      end else begin
         if (err > 0 && err_acc > sum_max - err) err_acc = sum_max;
         else if (err < 0 && err_acc < -sum_max - err) err_acc = -sum_max;
         else err_acc = err_acc + err;
         if (ki != 0) begin
            bound = (i_limit << FRAC_BITS) / {32'h0, ki};
            if (magnitude(err_acc) > bound)
               err_acc = (err_acc < 0) ? -longint'(bound) : longint'(bound);
         end
      end
      i = scale_gain(ki, err_acc);
      d = scale_gain(kd, err - last_err);
      last_err = err;
      if (magnitude(err) <= tol) arrived_q = 1'b1;
      r.drive = 32'(sat_word(p + i + d));
      r.arrived = arrived_q;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      pid_result_type want;
      if (reset) begin
         kp = '0;
         ki = '0;
         kd = '0;
         target = 0;
         i_limit = 64'(LIMIT_RESET_INT) << FRAC_BITS;
         i_range = 64'(RANGE_RESET_INT) << FRAC_BITS;
         tol = '0;
         first_pending = 1'b1;
         last_err = 0;
         err_acc = 0;
         arrived_q = 1'b0;
         drive_forecast.delete();
         mismatches = 0;
         awaiting = 0;
      end else begin
         if (psel && penable && pwrite && pready)
            write_register(paddr[ADDR_W-1:2], pwdata);
         if (rsp_valid && !rsp_stall) begin
            if (drive_forecast.size() == 0) begin
               mismatches++;
               $display("%0t: response with no request outstanding, drive %0d arrived %0b",
                        $time, rsp_drive, rsp_arrived);
            end else begin
               want = drive_forecast.pop_front();
               if (rsp_drive !== want.drive) begin
                  mismatches++;
                  $display("%0t: drive expected %0d, got %0d", $time, want.drive, rsp_drive);
               end
               if (rsp_arrived !== want.arrived) begin
                  mismatches++;
                  $display("%0t: arrived expected %0b, got %0b", $time, want.arrived,
                           rsp_arrived);
               end
            end
         end
         if (req_valid && !req_stall)
            drive_forecast.push_back(pid_step(req_measurement, req_restart, req_clear_arrived));
         awaiting = drive_forecast.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the PID core with directed requests at the field and register
// extremes, then random requests over several register settings and idle
// patterns on both channels; a checker beside the core forecasts and compares.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pidc_pkg::*;

   localparam int FRAC  = 16;
   localparam int SUM_W = 48;
   localparam int ONE   = 65536;
   localparam int LIMIT = 2000000;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic signed [31:0]      req_measurement;
   logic                    req_restart;
   logic                    req_clear_arrived;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [31:0]      rsp_drive;
   logic                    rsp_arrived;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [ADDR_W-1:0]       paddr;
   logic [DATA_W-1:0]       pwdata;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   int                      mismatches;
   int                      awaiting;
   int                      send_idle;
   int                      recv_idle;
   int                      cycles = 0;
   longint                  cur_target;

   pid_controller_windup_clamp_core #(
      .FRAC_BITS(FRAC),
      .SUM_WIDTH(SUM_W)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_measurement(req_measurement), .req_restart(req_restart),
      .req_clear_arrived(req_clear_arrived),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive), .rsp_arrived(rsp_arrived),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pid_drive_checker #(
      .FRAC_BITS(FRAC),
      .SUM_WIDTH(SUM_W)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_measurement(req_measurement), .req_restart(req_restart),
      .req_clear_arrived(req_clear_arrived),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_drive(rsp_drive), .rsp_arrived(rsp_arrived),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .awaiting(awaiting)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // tasks are entered and left at a falling edge
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0 || req_stall) @(negedge clock);
   endtask

   task automatic program_pid(input logic [31:0] gp, input logic [31:0] gi,
                              input logic [31:0] gd, input logic [31:0] sp,
                              input logic [31:0] lim, input logic [31:0] rng,
                              input logic [31:0] tl);
      drain_results();
      csr_write(REG_GAIN_P, gp);
      csr_write(REG_GAIN_I, gi);
      csr_write(REG_GAIN_D, gd);
      csr_write(REG_SETPOINT, sp);
      csr_write(REG_INT_LIMIT, lim);
      csr_write(REG_INT_RANGE, rng);
      csr_write(REG_ARRIVE_TOL, tl);
      cur_target = longint'(signed'(sp));
   endtask

   task automatic send_request(input logic [31:0] meas, input logic restart,
                               input logic clr);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_measurement <= meas;
      req_restart <= restart;
      req_clear_arrived <= clr;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [31:0] near_target(input int unsigned span);
      longint v;
      v = cur_target + longint'($urandom_range(span)) * ($urandom_range(1) ? 1 : -1);
      return v[31:0];
   endfunction

   task automatic send_random();
      int unsigned pick;
      logic [31:0] meas;
      pick = $urandom_range(99);
      if (pick < 50) meas = near_target(3 * ONE);
      else if (pick < 70) meas = near_target(200 * ONE);
      else if (pick < 90) meas = $urandom;
      else begin
         case ($urandom_range(3))
            0: meas = 32'h8000_0000;
            1: meas = 32'h7FFF_FFFF;
            2: meas = 32'h0;
            default: meas = cur_target[31:0];
         endcase
      end
      send_request(meas, $urandom_range(99) < 6, $urandom_range(99) < 15);
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_measurement = '0;
      req_restart = 1'b0;
      req_clear_arrived = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      send_idle = 26;
      recv_idle = 79;
      cur_target = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, first step
      send_request(32'h0, 1'b0, 1'b0);
      send_request(32'h0001_2345, 1'b0, 1'b1);

      program_pid(ONE, ONE / 2, ONE / 4, 10 * ONE, 20 * ONE, 50 * ONE, ONE);
      send_request(10 * ONE, 1'b1, 1'b0);
      send_request(10 * ONE - ONE / 2, 1'b0, 1'b0);
      send_request(9 * ONE, 1'b0, 1'b1);
      // wind up into the clamp
      repeat (6) send_request(2 * ONE, 1'b0, 1'b0);
      // large P zeroes the sum, then error saturation
      send_request(-100 * ONE, 1'b0, 1'b0);
      send_request(32'h8000_0000, 1'b0, 1'b0);
      send_request(30 * ONE, 1'b0, 1'b1);
      send_request(30 * ONE, 1'b1, 1'b0);

      // no integral gain: no clamp; negative error saturation
      program_pid(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'h8000_0000, 1'b0, 1'b1);
      send_request(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'h0, 1'b1, 1'b0);

      // zero range and limit, drive saturation
      program_pid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_request(32'h8000_0000, 1'b0, 1'b0);
      send_request(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_request(32'h7FFF_0000, 1'b0, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            1: program_pid(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            3: program_pid($urandom_range(2 * ONE), $urandom_range(ONE),
                           $urandom_range(ONE), 32'h8000_0000, 32'h0, 32'h0, 32'h0);
            5: program_pid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
            default: program_pid($urandom_range(3 * ONE), $urandom_range(ONE / 2, ONE / 64),
                                 $urandom_range(2 * ONE),
                                 $urandom_range(200 * ONE) - 100 * ONE,
                                 $urandom_range(40 * ONE), $urandom_range(200 * ONE),
                                 $urandom_range(2 * ONE));
         endcase
         for (int k = 0; k < 100; k++) begin
            n = ph * 100 + k;
            if (n == 200) begin
               send_idle = 79;
               recv_idle = 26;
            end
            if (n == 400) begin
               send_idle = 0;
               recv_idle = 0;
            end
            if (k == 50) drain_results();
            send_random();
         end
      end

      drain_results();
      repeat (64) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== pid_controller_windup_clamp_core.f =====
sv/pidc_pkg.sv
sv/pidc_mul.sv
sv/pidc_div.sv
sv/pid_controller_windup_clamp_core.sv
tb/pid_drive_checker.sv
tb/testbench.sv
